// ----- sv/i2cmts_pkg.sv -----
// Types and constants of the I2C master transfer sequencer.
// No dependencies; imported by i2c_master_transfer_sequencer_unit.
package i2cmts_pkg;

  // Sequencer phases
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_XFER  = 2'd2,
    PH_WIDLE = 2'd3
  } phase_t;

  // Request kinds on the input channel
  typedef enum logic [1:0] {
    K_BEGIN  = 2'd0,
    K_STATUS = 2'd1,
    K_TICK   = 2'd2,
    K_LOAD   = 2'd3
  } kind_t;

  // Result actions on the output channel
  typedef enum logic [1:0] {
    A_CTRL  = 2'd0,
    A_WRITE = 2'd1,
    A_RECV  = 2'd2,
    A_DONE  = 2'd3
  } action_t;

  // Controller status codes
  localparam logic [7:0] ST_START_OK  = 8'h08;
  localparam logic [7:0] ST_ADDR_W_A  = 8'h18;
  localparam logic [7:0] ST_ADDR_W_NA = 8'h20;
  localparam logic [7:0] ST_DATA_W_A  = 8'h28;
  localparam logic [7:0] ST_DATA_W_NA = 8'h30;
  localparam logic [7:0] ST_ADDR_R_A  = 8'h40;
  localparam logic [7:0] ST_ADDR_R_NA = 8'h48;
  localparam logic [7:0] ST_DATA_R_A  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NA = 8'h58;
  localparam logic [7:0] ST_IDLE      = 8'hf8;

  // Control register bits
  localparam logic [7:0] C_STA  = 8'h20;
  localparam logic [7:0] C_STP  = 8'h10;
  localparam logic [7:0] C_IFLG = 8'h08;
  localparam logic [7:0] C_AAK  = 8'h04;

  localparam logic [9:0]  ADDR_MAX        = 10'h07f;
  localparam logic [15:0] POLL_LIMIT_RST  = 16'd1000;
  localparam logic [15:0] POLL_SAT        = 16'hffff;

  // Register index on the configuration port
  localparam logic REG_POLL_LIMIT = 1'b0;

  // One result item
  typedef struct packed {
    action_t    action;
    logic [7:0] set_mask;
    logic [7:0] clear_mask;
    logic [7:0] byte_value;
    logic       failed;
    logic       last;
  } res_t;

  function automatic res_t mk_res(action_t act, logic [7:0] set_m, logic [7:0] clr_m,
                                  logic [7:0] val, logic fail);
    res_t r;
    r.action     = act;
    r.set_mask   = set_m;
    r.clear_mask = clr_m;
    r.byte_value = val;
    r.failed     = fail;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

// ----- sv/i2c_master_transfer_sequencer_unit.sv -----
// I2C master transfer sequencer: top level, single module.
// Depends on i2cmts_pkg for phase, kind and action codes and the result type.

// Each request is decoded in the cycle it is accepted: the phase registers update
// at that edge and its zero to three results drop into a four-entry result queue.
// A request is taken in any cycle in which the queue holds at most one result, so
// requests that cause no result (ticks, loads, ignored samples) stream at one per
// cycle, and the sustained rate is one request per cycle until results pile up,
// after which it follows the output side at one result per cycle. Transmit bytes
// sit in a TX_DEPTH-entry buffer whose read data is registered; the entry at the
// current byte index is fetched in the cycle before its use. No clearing pass.
module i2c_master_transfer_sequencer_unit #(
  parameter int TX_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // address[9:0], is_read[10], length[18:11], status_code[26:19],
  // data_byte[34:27], flag_set[35], zero[39:36]
  input  logic [39:0] in_tdata,
  // kind[1:0]
  input  logic [1:0]  in_tuser,
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // set_mask[7:0], clear_mask[15:8], byte_value[23:16], failed[24], zero[31:25]
  output logic [31:0] out_tdata,
  // action[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import i2cmts_pkg::*;

  localparam int IDX_W  = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int FILL_W = $clog2(TX_DEPTH + 1);

  // input fields
  kind_t      in_kind;
  logic [9:0] in_address;
  logic       in_is_read;
  logic [7:0] in_length;
  logic [7:0] in_status;
  logic [7:0] in_data;
  logic       in_flag;
  logic       in_acc;

  assign in_kind    = kind_t'(in_tuser);
  assign in_address = in_tdata[9:0];
  assign in_is_read = in_tdata[10];
  assign in_length  = in_tdata[18:11];
  assign in_status  = in_tdata[26:19];
  assign in_data    = in_tdata[34:27];
  assign in_flag    = in_tdata[35];
  assign in_acc     = in_tvalid && in_tready;

  // configuration register
  logic [15:0] poll_limit_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == REG_POLL_LIMIT);
  assign cfg_prdata = (cfg_paddr[2] == REG_POLL_LIMIT) ? {16'd0, poll_limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r <= POLL_LIMIT_RST;
    end else if (cfg_wr) begin
      poll_limit_r <= cfg_pwdata[15:0];
    end
  end

  // sequencer state
  phase_t            phase_r, phase_nxt;
  logic              dir_rd_r, dir_rd_nxt;
  logic [6:0]        taddr_r, taddr_nxt;
  logic [7:0]        tlen_r, tlen_nxt;
  logic [7:0]        bidx_r, bidx_nxt;
  logic              fail_r, fail_nxt;
  logic [15:0]       poll_r, poll_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  // transmit buffer, registered read, fetched in the cycle before its use
  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] tx_q_r;
  logic       tx_we;

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[fill_r[IDX_W-1:0]] <= in_data;
    end
    tx_q_r <= tx_mem[bidx_nxt[IDX_W-1:0]];
  end

  // results of the current request
  res_t       res [3];
  logic [1:0] n_res;
  logic [15:0] poll_inc;
  logic [7:0]  bidx_inc;
  logic [7:0]  tx_byte;

  assign poll_inc = (poll_r == POLL_SAT) ? poll_r : poll_r + 16'd1;
  assign bidx_inc = bidx_r + 8'd1;
  assign tx_byte  = ({1'b0, bidx_r} < 9'(TX_DEPTH)) ? tx_q_r : 8'd0;

  // decode of one request
  always_comb begin
    phase_nxt  = phase_r;
    dir_rd_nxt = dir_rd_r;
    taddr_nxt  = taddr_r;
    tlen_nxt   = tlen_r;
    bidx_nxt   = bidx_r;
    fail_nxt   = fail_r;
    poll_nxt   = poll_r;
    fill_nxt   = fill_r;
    tx_we      = 1'b0;
    n_res      = 2'd0;
    for (int k = 0; k < 3; k++) begin
      res[k] = mk_res(A_CTRL, 8'd0, 8'd0, 8'd0, 1'b0);
    end

    if (in_acc) begin
      unique case (in_kind)
        K_BEGIN: begin
          if (phase_r == PH_IDLE) begin
            n_res = 2'd1;
            if (in_address > ADDR_MAX || in_length == 8'd0) begin
              res[0]   = mk_res(A_DONE, 8'd0, 8'd0, 8'd0, in_address > ADDR_MAX);
              fill_nxt = '0;
            end else begin
              res[0]     = mk_res(A_CTRL, C_STA, 8'd0, 8'd0, 1'b0);
              dir_rd_nxt = in_is_read;
              taddr_nxt  = in_address[6:0];
              tlen_nxt   = in_length;
              bidx_nxt   = 8'd0;
              fail_nxt   = 1'b0;
              poll_nxt   = 16'd0;
              phase_nxt  = PH_START;
            end
          end
        end
        K_LOAD: begin
          if (phase_r == PH_IDLE && fill_r < FILL_W'(TX_DEPTH)) begin
            tx_we    = 1'b1;
            fill_nxt = fill_r + FILL_W'(1);
          end
        end
        K_TICK: begin
          if (phase_r == PH_START || phase_r == PH_XFER) begin
            poll_nxt = poll_inc;
            if (poll_inc >= poll_limit_r) begin
              res[0]    = mk_res(A_CTRL, C_STP, C_IFLG, 8'd0, 1'b0);
              n_res     = 2'd1;
              fail_nxt  = 1'b1;
              phase_nxt = PH_WIDLE;
            end
          end
        end
        K_STATUS: begin
          if (phase_r == PH_WIDLE) begin
            if (in_status == ST_IDLE) begin
              res[0]    = mk_res(A_DONE, 8'd0, 8'd0, 8'd0, fail_r);
              n_res     = 2'd1;
              phase_nxt = PH_IDLE;
              fill_nxt  = '0;
            end
          end else if (phase_r != PH_IDLE && in_flag) begin
            poll_nxt = 16'd0;
            if (phase_r == PH_START) begin
              if (in_status == ST_START_OK) begin
                res[0]    = mk_res(A_WRITE, 8'd0, 8'd0, {taddr_r, dir_rd_r}, 1'b0);
                res[1]    = mk_res(A_CTRL, 8'd0, C_IFLG, 8'd0, 1'b0);
                n_res     = 2'd2;
                phase_nxt = PH_XFER;
              end else begin
                res[0]    = mk_res(A_CTRL, C_STP, C_IFLG, 8'd0, 1'b0);
                n_res     = 2'd1;
                fail_nxt  = 1'b1;
                phase_nxt = PH_WIDLE;
              end
            end else if (!dir_rd_r && (in_status == ST_ADDR_W_A ||
                         in_status == ST_ADDR_W_NA || in_status == ST_DATA_W_A ||
                         in_status == ST_DATA_W_NA)) begin
              // write data byte
              res[0]   = mk_res(A_WRITE, 8'd0, 8'd0, tx_byte, 1'b0);
              res[1]   = mk_res(A_CTRL, 8'd0, C_IFLG, 8'd0, 1'b0);
              n_res    = 2'd2;
              bidx_nxt = bidx_inc;
              if (bidx_inc == tlen_r) begin
                res[2]    = mk_res(A_CTRL, C_STP, C_IFLG, 8'd0, 1'b0);
                n_res     = 2'd3;
                fail_nxt  = 1'b0;
                phase_nxt = PH_WIDLE;
              end
            end else if (dir_rd_r && in_status == ST_ADDR_R_A) begin
              res[0] = mk_res(A_CTRL, 8'd0, C_IFLG, 8'd0, 1'b0);
              n_res  = 2'd1;
            end else if (dir_rd_r && in_status == ST_ADDR_R_NA) begin
              res[0] = mk_res(A_CTRL, C_STA, C_IFLG, 8'd0, 1'b0);
              n_res  = 2'd1;
            end else if (dir_rd_r && (in_status == ST_DATA_R_A ||
                         in_status == ST_DATA_R_NA)) begin
              // received data byte
              res[0]   = mk_res(A_RECV, 8'd0, 8'd0, in_data, 1'b0);
              res[1]   = mk_res(A_CTRL, C_AAK, C_IFLG, 8'd0, 1'b0);
              n_res    = 2'd2;
              bidx_nxt = bidx_inc;
              if (bidx_inc == tlen_r) begin
                res[2]    = mk_res(A_CTRL, C_STP, C_IFLG, 8'd0, 1'b0);
                n_res     = 2'd3;
                fail_nxt  = 1'b0;
                phase_nxt = PH_WIDLE;
              end
            end else begin
              res[0]    = mk_res(A_CTRL, C_STP, C_IFLG, 8'd0, 1'b0);
              n_res     = 2'd1;
              fail_nxt  = 1'b1;
              phase_nxt = PH_WIDLE;
            end
          end
        end
        default: ;
      endcase
    end

    // mark the final result of this request
    for (int k = 0; k < 3; k++) begin
      if (2'(k + 1) == n_res) begin
        res[k].last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      dir_rd_r <= 1'b0;
      taddr_r  <= '0;
      tlen_r   <= '0;
      bidx_r   <= '0;
      fail_r   <= 1'b0;
      poll_r   <= '0;
      fill_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      dir_rd_r <= dir_rd_nxt;
      taddr_r  <= taddr_nxt;
      tlen_r   <= tlen_nxt;
      bidx_r   <= bidx_nxt;
      fail_r   <= fail_nxt;
      poll_r   <= poll_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // result queue, four entries
  res_t       q_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;
  logic       pop;

  assign in_tready  = (cnt_r <= 3'd1);
  assign out_tvalid = (cnt_r != 3'd0);
  assign pop        = out_tvalid && out_tready;
  assign out_tuser  = q_r[rd_ptr_r].action;
  assign out_tlast  = q_r[rd_ptr_r].last;
  assign out_tdata  = {7'd0, q_r[rd_ptr_r].failed, q_r[rd_ptr_r].byte_value,
                       q_r[rd_ptr_r].clear_mask, q_r[rd_ptr_r].set_mask};

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < n_res) begin
        q_r[wr_ptr_r + 2'(k)] <= res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + n_res;
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      cnt_r    <= cnt_r + {1'b0, n_res} - {2'b0, pop};
    end
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("result queue overflow");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(TX_DEPTH))
    else $error("transmit buffer fill beyond depth");

  a_begin_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == K_BEGIN && phase_r == PH_IDLE &&
     in_address <= ADDR_MAX && in_length != 8'd0) |=> phase_r == PH_START)
    else $error("valid begin did not enter start phase");

  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (n_res != 2'd0) |-> in_acc)
    else $error("results produced without an accepted request");

endmodule

// ----- tb/i2cmts_sequence_checker.sv -----
`timescale 1ns / 100ps
// Checker for the I2C master transfer sequencer: predicts the result stream
// from accepted requests and register writes, and compares field by field.
// Depends on i2cmts_pkg; instantiated beside the DUT by tb.
module i2cmts_sequence_checker #(
  parameter int TX_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // address[9:0], is_read[10], length[18:11], status_code[26:19],
  // data_byte[34:27], flag_set[35], zero[39:36]
  input  logic [39:0] in_tdata,
  // kind[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // set_mask[7:0], clear_mask[15:8], byte_value[23:16], failed[24], zero[31:25]
  input  logic [31:0] out_tdata,
  // action[1:0]
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          mismatch_count,
  output int          pending_count
);
  import i2cmts_pkg::*;

  localparam logic [2:0] POLL_LIMIT_ADDR = 3'(REG_POLL_LIMIT) << 2;

  // predicted sequencer state
  phase_t      seq_phase;
  logic        dir_read;
  logic [6:0]  dev_addr;
  logic [7:0]  xfer_len;
  logic [7:0]  byte_idx;
  logic        fail_latched;
  logic [15:0] tick_count;
  logic [15:0] poll_limit;
  logic [7:0]  tx_bytes [TX_DEPTH];
  int          tx_fill;

  // bus actions still owed by the DUT, oldest first
  res_t        due_actions [$];
  int          mismatches = 0;
  int          due_count = 0;

  assign mismatch_count = mismatches;
  assign pending_count  = due_count;

  task automatic queue_action(action_t act, logic [7:0] set_m, logic [7:0] clr_m,
                              logic [7:0] val, logic fail);
    res_t r;
    r.action     = act;
    r.set_mask   = set_m;
    r.clear_mask = clr_m;
    r.byte_value = val;
    r.failed     = fail;
    r.last       = 1'b0;
    due_actions.push_back(r);
  endtask

  // failure: request a stop and wait for the idle status
  task automatic abort_transfer();
    fail_latched = 1'b1;
    seq_phase    = PH_WIDLE;
    queue_action(A_CTRL, C_STP, C_IFLG, 8'h00, 1'b0);
  endtask

  task automatic end_transfer(logic fail);
    seq_phase = PH_IDLE;
    tx_fill   = 0;
    queue_action(A_DONE, 8'h00, 8'h00, 8'h00, fail);
  endtask

  // one data byte moved; the stop follows right after the last one
  task automatic count_data_byte();
    byte_idx = byte_idx + 8'd1;
    if (byte_idx == xfer_len) begin
      fail_latched = 1'b0;
      seq_phase    = PH_WIDLE;
      queue_action(A_CTRL, C_STP, C_IFLG, 8'h00, 1'b0);
    end
  endtask

  task automatic predict_step(kind_t k, logic [39:0] d);
    logic [9:0] addr;
    logic       rd;
    logic [7:0] len;
    logic [7:0] st;
    logic [7:0] db;
    logic       flg;
    logic [7:0] wbyte;
    res_t       tail;
    int         first;
    addr  = d[9:0];
    rd    = d[10];
    len   = d[18:11];
    st    = d[26:19];
    db    = d[34:27];
    flg   = d[35];
    first = due_actions.size();
    case (k)
      K_BEGIN: begin
        if (seq_phase == PH_IDLE) begin
          if (addr > ADDR_MAX) begin
            end_transfer(1'b1);
          end else if (len == 8'd0) begin
            end_transfer(1'b0);
          end else begin
            dir_read     = rd;
            dev_addr     = addr[6:0];
            xfer_len     = len;
            byte_idx     = 8'd0;
            fail_latched = 1'b0;
            tick_count   = 16'd0;
            seq_phase    = PH_START;
            queue_action(A_CTRL, C_STA, 8'h00, 8'h00, 1'b0);
          end
        end
      end
      K_LOAD: begin
        if (seq_phase == PH_IDLE && tx_fill < TX_DEPTH) begin
          tx_bytes[tx_fill] = db;
          tx_fill++;
        end
      end
      K_TICK: begin
        if (seq_phase == PH_START || seq_phase == PH_XFER) begin
          if (tick_count != POLL_SAT) tick_count = tick_count + 16'd1;
          if (tick_count >= poll_limit) abort_transfer();
        end
      end
      K_STATUS: begin
        if (seq_phase == PH_WIDLE) begin
          // flag is ignored while waiting for the bus to go idle
          if (st == ST_IDLE) end_transfer(fail_latched);
        end else if (seq_phase != PH_IDLE && flg) begin
          tick_count = 16'd0;
          if (seq_phase == PH_START) begin
            if (st != ST_START_OK) begin
              abort_transfer();
            end else begin
              queue_action(A_WRITE, 8'h00, 8'h00, {dev_addr, dir_read}, 1'b0);
              queue_action(A_CTRL, 8'h00, C_IFLG, 8'h00, 1'b0);
              seq_phase = PH_XFER;
            end
          end else if (!dir_read) begin
            if (st == ST_ADDR_W_A || st == ST_ADDR_W_NA ||
                st == ST_DATA_W_A || st == ST_DATA_W_NA) begin
              // bytes past the buffer go out as zero
              wbyte = 8'h00;
              if (byte_idx < TX_DEPTH) wbyte = tx_bytes[byte_idx];
              queue_action(A_WRITE, 8'h00, 8'h00, wbyte, 1'b0);
              queue_action(A_CTRL, 8'h00, C_IFLG, 8'h00, 1'b0);
              count_data_byte();
            end else begin
              abort_transfer();
            end
          end else if (st == ST_ADDR_R_A) begin
            queue_action(A_CTRL, 8'h00, C_IFLG, 8'h00, 1'b0);
          end else if (st == ST_ADDR_R_NA) begin
            queue_action(A_CTRL, C_STA, C_IFLG, 8'h00, 1'b0);
          end else if (st == ST_DATA_R_A || st == ST_DATA_R_NA) begin
            queue_action(A_RECV, 8'h00, 8'h00, db, 1'b0);
            queue_action(A_CTRL, C_AAK, C_IFLG, 8'h00, 1'b0);
            count_data_byte();
          end else begin
            abort_transfer();
          end
        end
      end
    endcase
    // mark the final action caused by this request
    if (due_actions.size() > first) begin
      tail = due_actions.pop_back();
      tail.last = 1'b1;
      due_actions.push_back(tail);
    end
  endtask

  task automatic compare_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endtask

  task automatic check_bus_action();
    res_t want;
    if (due_actions.size() == 0) begin
      $error("result with nothing expected: action %0d, data %h", out_tuser, out_tdata);
      mismatches++;
    end else begin
      want = due_actions.pop_front();
      compare_field("action", 8'(want.action), 8'(out_tuser));
      compare_field("set_mask", want.set_mask, out_tdata[7:0]);
      compare_field("clear_mask", want.clear_mask, out_tdata[15:8]);
      compare_field("byte_value", want.byte_value, out_tdata[23:16]);
      compare_field("failed", 8'(want.failed), 8'(out_tdata[24]));
      compare_field("last", 8'(want.last), 8'(out_tlast));
    end
  endtask

  // watch register access, requests and results at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      seq_phase    = PH_IDLE;
      dir_read     = 1'b0;
      dev_addr     = 7'd0;
      xfer_len     = 8'd0;
      byte_idx     = 8'd0;
      fail_latched = 1'b0;
      tick_count   = 16'd0;
      poll_limit   = POLL_LIMIT_RST;
      tx_fill      = 0;
      due_actions.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == POLL_LIMIT_ADDR) begin
        if (cfg_pwrite) begin
          poll_limit = cfg_pwdata[15:0];
        end else if (cfg_prdata !== {16'h0000, poll_limit}) begin
          $error("poll_limit readback mismatch: expected %0h, got %0h", poll_limit, cfg_prdata);
          mismatches++;
        end
      end
      if (in_tvalid && in_tready) predict_step(kind_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) check_bus_action();
    end
    due_count <= due_actions.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the I2C master transfer sequencer: clock, reset, request
// and register stimulus, result-side stalls, watchdog and verdict.
// Depends on i2cmts_pkg, i2c_master_transfer_sequencer_unit, i2cmts_sequence_checker.
module tb;
  import i2cmts_pkg::*;

  localparam int TX_DEPTH       = 16;
  localparam int RANDOM_ITEMS   = 240;
  localparam int QUIET_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int SQUEEZE_CYCLES = 120;
  localparam logic [2:0] POLL_LIMIT_ADDR = 3'(REG_POLL_LIMIT) << 2;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          mismatch_count;
  int          pending_count;

  // sender pacing and item bookkeeping
  int          burst_left = 0;
  int          gap_max = 6;
  int          item_count = 0;
  logic        squeeze_req = 1'b0;

  // result-side pattern
  int          run_left = 0;
  int          hold_left = 0;
  logic        squeeze_done = 1'b0;
  int          quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  i2c_master_transfer_sequencer_unit #(.TX_DEPTH(TX_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  i2cmts_sequence_checker #(.TX_DEPTH(TX_DEPTH)) seq_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  // result side: random ready runs, plus one long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready   <= 1'b0;
      run_left     <= 0;
      hold_left    <= 0;
      squeeze_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (squeeze_req && !squeeze_done) begin
      out_tready   <= 1'b0;
      hold_left    <= SQUEEZE_CYCLES;
      squeeze_done <= 1'b1;
    end else if (run_left != 0) begin
      run_left <= run_left - 1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
      run_left   <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [39:0] random_payload();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[39:0];
  endfunction

  // offer one request; bursts with random gaps between them unless gap_max is zero
  task automatic push_request(kind_t k, logic [39:0] payload);
    if (burst_left == 0 && gap_max != 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left != 0) burst_left--;
    item_count++;
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {4'h0, payload[35:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_begin(logic [9:0] addr, logic rd, logic [7:0] len);
    logic [39:0] p;
    p = random_payload();
    p[9:0]   = addr;
    p[10]    = rd;
    p[18:11] = len;
    push_request(K_BEGIN, p);
  endtask

  task automatic send_sample(logic [7:0] st, logic [7:0] db, logic flg);
    logic [39:0] p;
    p = random_payload();
    p[26:19] = st;
    p[34:27] = db;
    p[35]    = flg;
    push_request(K_STATUS, p);
  endtask

  task automatic send_tick();
    push_request(K_TICK, random_payload());
  endtask

  task automatic send_load(logic [7:0] db);
    logic [39:0] p;
    p = random_payload();
    p[34:27] = db;
    push_request(K_LOAD, p);
  endtask

  // stray requests: ticks (sometimes in runs, for timeouts), unflagged
  // samples, loads and begins that land on a busy sequencer
  task automatic scatter_noise(int pct);
    int n;
    if ($urandom_range(1, 100) > pct) return;
    n = $urandom_range(1, 3);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0, 1:    send_tick();
        2:       repeat ($urandom_range(2, 8)) send_tick();
        3:       send_sample(8'($urandom), 8'($urandom), 1'b0);
        4:       send_load(8'($urandom));
        default: send_begin(10'($urandom), 1'($urandom), 8'($urandom));
      endcase
    end
  endtask

  // one transfer as the controller would report it, with optional noise and
  // faults; two flagged idle samples at the end always bring it back to idle
  task automatic run_transfer(logic [9:0] addr, logic rd, logic [7:0] len,
                              int noise_pct, int fault_pct);
    int         steps;
    logic [7:0] code;
    send_begin(addr, rd, len);
    if (addr > ADDR_MAX || len == 8'd0) return;
    scatter_noise(noise_pct);
    code = ST_START_OK;
    if ($urandom_range(1, 100) <= fault_pct) code = 8'($urandom);
    send_sample(code, 8'($urandom), 1'b1);
    // long transfers are cut short; the closing samples fail them
    steps = (len > 8'd24) ? $urandom_range(1, 24) : int'(len);
    for (int i = 0; i < steps; i++) begin
      scatter_noise(noise_pct);
      if ($urandom_range(1, 100) <= fault_pct) begin
        send_sample(8'($urandom), 8'($urandom), 1'b1);
      end else if (!rd) begin
        case ($urandom_range(0, 3))
          0:       code = ST_ADDR_W_A;
          1:       code = ST_ADDR_W_NA;
          2:       code = ST_DATA_W_A;
          default: code = ST_DATA_W_NA;
        endcase
        send_sample(code, 8'($urandom), 1'b1);
      end else begin
        if (i == 0 && $urandom_range(0, 1) == 1) send_sample(ST_ADDR_R_A, 8'($urandom), 1'b1);
        if ($urandom_range(0, 9) == 0) send_sample(ST_ADDR_R_NA, 8'($urandom), 1'b1);
        send_sample(($urandom_range(0, 1) == 1) ? ST_DATA_R_A : ST_DATA_R_NA,
                    8'($urandom), 1'b1);
      end
    end
    scatter_noise(noise_pct);
    send_sample(ST_IDLE, 8'($urandom), 1'b1);
    send_sample(ST_IDLE, 8'($urandom), 1'b1);
  endtask

  // stop offering, wait until every result is in, then let the block settle
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write followed by a readback
  task automatic write_poll_limit(logic [15:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= POLL_LIMIT_ADDR;
    cfg_pwdata  <= {16'h0000, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin
    logic [15:0] limit;
    logic [9:0]  addr;
    logic [7:0]  len;
    int          target;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every transmit entry, then one load past the end
    send_load(8'h00);
    send_load(8'hff);
    for (int i = 2; i <= TX_DEPTH; i++) send_load(8'($urandom));
    // samples and ticks in idle are ignored
    send_tick();
    send_sample(ST_IDLE, 8'h00, 1'b1);
    // address out of range, then zero length
    send_begin(10'h3ff, 1'b1, 8'hff);
    send_begin(10'h080, 1'b0, 8'd1);
    send_begin(10'h000, 1'b0, 8'd0);
    // clean write through all four data-phase codes
    send_begin(ADDR_MAX, 1'b0, 8'd4);
    send_sample(ST_START_OK, 8'h00, 1'b1);
    send_sample(ST_ADDR_W_A, 8'h00, 1'b1);
    send_sample(ST_ADDR_W_NA, 8'h00, 1'b1);
    send_sample(ST_DATA_W_A, 8'h00, 1'b1);
    send_sample(ST_DATA_W_NA, 8'h00, 1'b1);
    send_sample(ST_IDLE, 8'h00, 1'b0);
    // read with address ack, repeated start and both data codes
    send_begin(10'h055, 1'b1, 8'd2);
    send_sample(ST_START_OK, 8'h00, 1'b1);
    send_sample(ST_ADDR_R_A, 8'h00, 1'b1);
    send_sample(ST_ADDR_R_NA, 8'h00, 1'b1);
    send_sample(ST_DATA_R_A, 8'hff, 1'b1);
    send_sample(ST_DATA_R_NA, 8'h00, 1'b1);
    send_sample(ST_IDLE, 8'hff, 1'b1);
    // wrong code at the start check
    send_begin(10'h000, 1'b0, 8'd1);
    send_sample(ST_DATA_W_A, 8'h00, 1'b1);
    send_sample(ST_IDLE, 8'h00, 1'b1);
    settle();

    // random transfers under several poll limits, extremes first
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       limit = 16'd1;
        1:       limit = 16'hffff;
        2:       limit = 16'($urandom_range(2, 6));
        default: limit = 16'($urandom_range(1, 65535));
      endcase
      write_poll_limit(limit);
      if (ph == 1) squeeze_req <= 1'b1;
      gap_max = (ph == 2) ? 0 : 6;
      target  = item_count + RANDOM_ITEMS / 4;
      while (item_count < target) begin
        repeat ($urandom_range(0, 3)) send_load(8'($urandom));
        addr = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 127));
        case ($urandom_range(0, 15))
          0:       len = 8'd0;
          1:       len = 8'($urandom_range(25, 255));
          2, 3:    len = 8'($urandom_range(TX_DEPTH + 1, 24));
          default: len = 8'($urandom_range(1, 8));
        endcase
        run_transfer(addr, 1'($urandom), len, 30, ($urandom_range(0, 3) == 0) ? 10 : 0);
      end
      settle();
    end

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
